FILE: design/bldc_six_step_commutator_defines.svh
// ----------------------------------------------------------------------------
// bldc_six_step_commutator_defines
// Assertion macros used by the checker file of the commutator.
// ----------------------------------------------------------------------------
`ifndef BLDC_SIX_STEP_COMMUTATOR_DEFINES_SVH
`define BLDC_SIX_STEP_COMMUTATOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define BSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("commutator check failed");

// Check a consequent in the cycle after its antecedent.
`define BSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("commutator check failed");

`endif

FILE: design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Widths, register codes, reset values and commutation tables of the
// six-step commutator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

	localparam int PWM_W      = 16;
	localparam int TICK_W     = 32;
	localparam int INTERVAL_W = 32;
	localparam int STEP_COUNT = 6;
	localparam int STEP_W     = $clog2(STEP_COUNT);
	localparam int GATE_W     = 6;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	typedef logic [PWM_W-1:0]      pwm_t;
	typedef logic [TICK_W-1:0]     tick_t;
	typedef logic [INTERVAL_W-1:0] interval_t;
	typedef logic [STEP_W-1:0]     step_t;
	typedef logic [GATE_W-1:0]     gate_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_TICKS      = 3'd0,
		REG_DUTY_WIDTH        = 3'd1,
		REG_ADC_TRIGGER_WIDTH = 3'd2,
		REG_COMM_INTERVAL     = 3'd3,
		REG_DIRECTION_FORWARD = 3'd4
	} cfg_reg_t;

	localparam pwm_t      RST_PERIOD_TICKS      = 16'd1000;
	localparam pwm_t      RST_DUTY_WIDTH        = 16'd180;
	localparam pwm_t      RST_ADC_TRIGGER_WIDTH = 16'd950;
	localparam interval_t RST_COMM_INTERVAL     = 32'd20000;
	localparam logic      RST_DIRECTION_FORWARD = 1'b1;

	localparam step_t LAST_STEP = step_t'(STEP_COUNT - 1);

	typedef struct packed {
		pwm_t      period_ticks;
		pwm_t      duty_width;
		pwm_t      adc_trigger_width;
		interval_t commutation_interval;
		logic      direction_forward;
	} cfg_t;

	typedef struct packed {
		gate_t gates;
		logic  expect_zero_cross;
		logic  adc_trigger;
		step_t commutation_step;
	} result_t;

	// On-time gate pattern of a step: one phase high, one phase low
	function automatic gate_t on_pattern_of(input step_t s);
		gate_t p;
		case (s)
			3'd0:    p = 6'h09;
			3'd1:    p = 6'h21;
			3'd2:    p = 6'h24;
			3'd3:    p = 6'h06;
			3'd4:    p = 6'h12;
			3'd5:    p = 6'h18;
			default: p = '0;
		endcase
		return p;
	endfunction

	// Off-time gate pattern of a step: low side only
	function automatic gate_t off_pattern_of(input step_t s);
		gate_t p;
		case (s)
			3'd0:    p = 6'h08;
			3'd1:    p = 6'h20;
			3'd2:    p = 6'h20;
			3'd3:    p = 6'h02;
			3'd4:    p = 6'h02;
			3'd5:    p = 6'h08;
			default: p = '0;
		endcase
		return p;
	endfunction

	// Expected zero-cross flag of a step
	function automatic logic zero_cross_of(input step_t s);
		logic z;
		case (s)
			3'd1, 3'd3, 3'd5: z = 1'b1;
			default:          z = 1'b0;
		endcase
		return z;
	endfunction

	// Advance or retreat one step modulo the step count
	function automatic step_t move_step(input step_t s, input logic fwd);
		step_t n;
		if (fwd) begin
			n = (s >= LAST_STEP) ? '0 : step_t'(s + step_t'(1));
		end else begin
			n = (s == '0) ? LAST_STEP : step_t'(s - step_t'(1));
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: design/bsc_in_if.sv
// ----------------------------------------------------------------------------
// bsc_in_if
// Tick channel: one item per timer tick carrying the run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_in_if;
	logic valid;
	logic ready;
	logic run;

	modport source (output valid, output run, input ready);
	modport sink   (input valid, input run, output ready);
endinterface

`default_nettype wire

FILE: design/bsc_out_if.sv
// ----------------------------------------------------------------------------
// bsc_out_if
// Result channel: gate drives, step index and flags of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] gates;
	logic       expect_zero_cross;
	logic       adc_trigger;
	logic [2:0] commutation_step;

	modport source (output valid, output gates, output expect_zero_cross,
		output adc_trigger, output commutation_step, input ready);
	modport sink   (input valid, input gates, input expect_zero_cross,
		input adc_trigger, input commutation_step, output ready);
endinterface

`default_nettype wire

FILE: design/bldc_six_step_commutator.sv
// ----------------------------------------------------------------------------
// bldc_six_step_commutator
// Open-loop six-step BLDC commutator with high-side PWM.
//
//   channel     dir  payload                                         per item
//   tick_in     in   run                                             one tick
//   result_out  out  gates, expect_zero_cross, adc_trigger,          one result
//                    commutation_step
//   wr_*        in   wr_index, wr_data                               one register
//
// One tick is taken per clock unless the result register is stalled; each
// tick passes an input register and then a result register to the output.
// The commutation state advances as a tick moves from the input register to
// the result register.
// A stalled result holds both stages; the input side stays ready while the
// input register is empty. Reset clears the core gate drive and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_six_step_commutator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bsc_in_if.sink                              tick_in,
	bsc_out_if.source                           result_out,
	input  wire logic                           wr_en,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bsc_pkg::CFG_DATA_W-1:0] wr_data
);
	import bsc_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_s2;
	logic    valid_s1, valid_s2;
	logic    run_s1;
	logic    advance;

	bsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.run    (run_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Move items forward unless the result register is stalled
	assign advance       = !valid_s2 || result_out.ready;
	assign tick_in.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_in.valid && tick_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in.valid && tick_in.ready) begin
			run_s1 <= tick_in.run;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign result_out.valid             = valid_s2;
	assign result_out.gates             = res_s2.gates;
	assign result_out.expect_zero_cross = res_s2.expect_zero_cross;
	assign result_out.adc_trigger       = res_s2.adc_trigger;
	assign result_out.commutation_step  = res_s2.commutation_step;

endmodule

`default_nettype wire

FILE: design/bsc_cfg.sv
// ----------------------------------------------------------------------------
// bsc_cfg
// Configuration register file with plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bsc_pkg::CFG_DATA_W-1:0] wr_data,
	output bsc_pkg::cfg_t                       cfg
);
	import bsc_pkg::*;

	cfg_t cfg_q;

	// Decode the index and write the selected register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ticks         <= RST_PERIOD_TICKS;
			cfg_q.duty_width           <= RST_DUTY_WIDTH;
			cfg_q.adc_trigger_width    <= RST_ADC_TRIGGER_WIDTH;
			cfg_q.commutation_interval <= RST_COMM_INTERVAL;
			cfg_q.direction_forward    <= RST_DIRECTION_FORWARD;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_PERIOD_TICKS:      cfg_q.period_ticks <= wr_data[PWM_W-1:0];
				REG_DUTY_WIDTH:        cfg_q.duty_width <= wr_data[PWM_W-1:0];
				REG_ADC_TRIGGER_WIDTH: cfg_q.adc_trigger_width <= wr_data[PWM_W-1:0];
				REG_COMM_INTERVAL:     cfg_q.commutation_interval <= wr_data[INTERVAL_W-1:0];
				REG_DIRECTION_FORWARD: cfg_q.direction_forward <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: design/bsc_core.sv
// ----------------------------------------------------------------------------
// bsc_core
// Commutation state and PWM counter; computes the result of one tick
// and updates the state when the tick is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          run,
	input  wire bsc_pkg::cfg_t cfg,
	output bsc_pkg::result_t   res
);
	import bsc_pkg::*;

	pwm_t  pwm_count_q, pwm_count_d;
	tick_t elapsed_q, elapsed_d, elapsed_inc;
	step_t current_step_q, current_step_d;
	step_t pending_step_q, pending_step_d;
	gate_t on_pattern_q, on_pattern_d;
	gate_t off_pattern_q, off_pattern_d;
	gate_t gate_drive_q, gate_drive_d;
	pwm_t  duty;
	logic  adc;
	logic [PWM_W:0] pwm_next;

	// Next state of one tick
	always_comb begin
		pwm_count_d    = pwm_count_q;
		elapsed_d      = elapsed_q;
		current_step_d = current_step_q;
		pending_step_d = pending_step_q;
		on_pattern_d   = on_pattern_q;
		off_pattern_d  = off_pattern_q;
		gate_drive_d   = gate_drive_q;
		adc            = 1'b0;
		duty = (cfg.duty_width > cfg.adc_trigger_width) ? cfg.adc_trigger_width
			: cfg.duty_width;
		elapsed_inc = (elapsed_q != '1) ? tick_t'(elapsed_q + tick_t'(1)) : elapsed_q;
		pwm_next = {1'b0, pwm_count_q} + (PWM_W+1)'(1);

		if (!run) begin
			gate_drive_d = '0;
			pwm_count_d  = '0;
		end else begin
			elapsed_d = elapsed_inc;
			// Cycle start: drive on pattern, check the commutation schedule
			if (pwm_count_q == '0) begin
				gate_drive_d = on_pattern_q;
				if (elapsed_inc >= tick_t'(cfg.commutation_interval)) begin
					pending_step_d = move_step(pending_step_q, cfg.direction_forward);
					elapsed_d = elapsed_inc - tick_t'(cfg.commutation_interval);
				end
			end
			// Duty compare: drive off pattern, latch the new step
			if (pwm_count_q == duty) begin
				gate_drive_d   = off_pattern_q;
				current_step_d = pending_step_d;
				on_pattern_d   = on_pattern_of(pending_step_d);
				off_pattern_d  = off_pattern_of(pending_step_d);
			end
			adc = (pwm_count_q == cfg.adc_trigger_width);
			// Advance the counter, wrap at the period
			if (cfg.period_ticks == '0 || pwm_next >= {1'b0, cfg.period_ticks}) begin
				pwm_count_d = '0;
			end else begin
				pwm_count_d = pwm_next[PWM_W-1:0];
			end
		end
	end

	// Hold state until a tick is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_count_q    <= '0;
			elapsed_q      <= '0;
			current_step_q <= '0;
			pending_step_q <= '0;
			on_pattern_q   <= '0;
			off_pattern_q  <= '0;
			gate_drive_q   <= '0;
		end else if (en) begin
			pwm_count_q    <= pwm_count_d;
			elapsed_q      <= elapsed_d;
			current_step_q <= current_step_d;
			pending_step_q <= pending_step_d;
			on_pattern_q   <= on_pattern_d;
			off_pattern_q  <= off_pattern_d;
			gate_drive_q   <= gate_drive_d;
		end
	end

	assign res.gates             = gate_drive_d;
	assign res.expect_zero_cross = zero_cross_of(current_step_d);
	assign res.adc_trigger       = adc;
	assign res.commutation_step  = current_step_d;

endmodule

`default_nettype wire

FILE: design/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the commutator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bldc_six_step_commutator_defines.svh"

module bsc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [5:0] gates,
	input wire logic       expect_zero_cross,
	input wire logic       adc_trigger,
	input wire logic [2:0] commutation_step
);

	// A stalled item holds its gates, step index and ADC trigger
	`BSC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(gates) && $stable(commutation_step) && $stable(adc_trigger))

	// Step index stays within the six steps
	`BSC_ASSERT_NOW(a_step_range, out_valid, commutation_step <= 3'd5)

	// Zero-cross flag follows the parity of the step
	`BSC_ASSERT_NOW(a_zc_parity, out_valid, expect_zero_cross == commutation_step[0])

	// Never drive high and low side of one phase together
	`BSC_ASSERT_NOW(a_no_shoot_through, out_valid, (gates[0] && gates[1]) == 1'b0 && (gates[2] && gates[3]) == 1'b0 && (gates[4] && gates[5]) == 1'b0)

endmodule

bind bldc_six_step_commutator bsc_checker u_bsc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (result_out.valid),
	.out_ready         (result_out.ready),
	.gates             (result_out.gates),
	.expect_zero_cross (result_out.expect_zero_cross),
	.adc_trigger       (result_out.adc_trigger),
	.commutation_step  (result_out.commutation_step)
);

`default_nettype wire
